FILE: src/lcn_pkg.sv
// ----------------------------------------------------------------------------
// lcn_pkg
// shared types and constants of the negative-caching lru cache
// ----------------------------------------------------------------------------
package lcn_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int SLOT_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam logic [31:0] RETRY_MS_RESET = 32'd60000;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_HOLD     = 3'd1,
    ST_MISS     = 3'd2,
    ST_INSERTED = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  // one cache slot as stored in the entry memory
  typedef struct packed {
    logic [63:0] tag;
    logic [31:0] handle;
    logic [63:0] stamp;   // use stamp when positive, deadline when negative
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // what one pass over the entry memory found
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [31:0]       hit_handle;
    logic [63:0]       hit_stamp;
    logic              free_any;
    logic [SLOT_W-1:0] free_slot;
    logic              neg_any;
    logic [SLOT_W-1:0] neg_slot;
    logic [SLOT_W-1:0] lru_slot;
    logic [31:0]       lru_handle;
  } scan_res_t;

endpackage

FILE: src/lcn_ram.sv
// ----------------------------------------------------------------------------
// lcn_ram
// single-port-write, single-port-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module lcn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/lcn_scan.sv
// ----------------------------------------------------------------------------
// lcn_scan
// walks the entry read stream one slot a cycle and keeps the tag match,
// first free slot, first negative slot and least recently used slot
// ----------------------------------------------------------------------------
module lcn_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      dvld,
  input  logic [lcn_pkg::SLOT_W-1:0] dslot,
  input  logic                      dvalid,
  input  lcn_pkg::entry_t           rdata,
  input  logic [63:0]               key,
  output lcn_pkg::scan_res_t        res
);

  logic        lru_any;
  logic [63:0] lru_stamp;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.hit      <= 1'b0;
      res.free_any <= 1'b0;
      res.neg_any  <= 1'b0;
      lru_any      <= 1'b0;
    end else if (dvld) begin
      if (!dvalid) begin
        if (!res.free_any) begin
          res.free_any  <= 1'b1;
          res.free_slot <= dslot;
        end
      end else begin
        if (!res.hit && rdata.tag == key) begin
          res.hit        <= 1'b1;
          res.hit_slot   <= dslot;
          res.hit_handle <= rdata.handle;
          res.hit_stamp  <= rdata.stamp;
        end
        if (!res.neg_any && rdata.handle == 32'd0) begin
          res.neg_any  <= 1'b1;
          res.neg_slot <= dslot;
        end
        // strict compare keeps the lowest slot on equal stamps
        if (!lru_any || rdata.stamp < lru_stamp) begin
          lru_any        <= 1'b1;
          lru_stamp      <= rdata.stamp;
          res.lru_slot   <= dslot;
          res.lru_handle <= rdata.handle;
        end
      end
    end
  end

endmodule

FILE: src/lru_cache_negative_entries.sv
// ----------------------------------------------------------------------------
// lru_cache_negative_entries
// fully associative tag-to-handle cache with lru eviction and negative
// entries that hold retries until a deadline
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | req_type, key_tag, handle_in, now_ms
//  out     | out_valid / out_stall | status, handle_out, evicted,
//          |                       | evicted_handle
//  cfg     | cfg_we                | cfg_wdata (retry_ms)
//
//  a lookup or insert is taken in the idle state, reads the entry memory
//  once per slot in the scan state, receives the registered read data of
//  the last slot, then decides and writes back in the decide step. a clear
//  or unused request goes from the idle state straight to the decide step.
//  reset clears the valid flip-flops and use counter; there is no clearing pass.
//  a result waits in the output register while the next transaction is
//  already taken and scanned; a stalled output holds the decide step.
// ----------------------------------------------------------------------------
module lru_cache_negative_entries (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [63:0] key_tag,
  input  logic [31:0] handle_in,
  input  logic [47:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] handle_out,
  output logic        evicted,
  output logic [31:0] evicted_handle
);

  localparam int N = lcn_pkg::CACHE_ENTRIES;

  lcn_pkg::state_t state, state_next;

  logic [31:0]                retry_ms;
  logic [63:0]                use_counter;
  logic [N-1:0]               entry_valid;
  logic [lcn_pkg::CNT_W-1:0]  cnt;

  logic [1:0]  req_q;
  logic [63:0] key_q;
  logic [31:0] hin_q;
  logic [47:0] now_q;

  logic                       in_acc;
  logic                       decide_go;
  logic                       ram_re;
  logic                       ram_we;
  logic [lcn_pkg::SLOT_W-1:0] ram_raddr;
  logic [lcn_pkg::ENTRY_W-1:0] ram_rdata;
  logic                       rd_vld;
  logic [lcn_pkg::SLOT_W-1:0] rd_slot;
  logic                       scan_last;

  lcn_pkg::scan_res_t sres;
  lcn_pkg::entry_t    rd_entry;

  // decide step
  logic                       wr_en;
  logic [lcn_pkg::SLOT_W-1:0] wr_slot;
  lcn_pkg::entry_t            wr_entry;
  logic                       set_valid;
  logic                       clr_valid;
  logic                       clear_all;
  logic                       cnt_load;
  logic [63:0]                cnt_val;
  logic [2:0]                 st_d;
  logic [31:0]                hout_d;
  logic                       ev_d;
  logic [31:0]                evh_d;
  logic [63:0]                cnt_inc;
  logic [63:0]                deadline;
  logic [lcn_pkg::SLOT_W-1:0] ins_slot;

  assign in_acc    = in_valid && !in_stall;
  assign scan_last = (cnt == lcn_pkg::CNT_W'(N));
  assign ram_raddr = cnt[lcn_pkg::SLOT_W-1:0];
  assign rd_entry  = lcn_pkg::entry_t'(ram_rdata);
  assign ram_we    = decide_go && wr_en;

  lcn_ram #(
    .WIDTH (lcn_pkg::ENTRY_W),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lcn_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (in_acc),
    .dvld   (rd_vld),
    .dslot  (rd_slot),
    .dvalid (entry_valid[rd_slot]),
    .rdata  (rd_entry),
    .key    (key_q),
    .res    (sres)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lcn_pkg::S_IDLE: begin
        if (in_valid) begin
          if (req_type == lcn_pkg::REQ_LOOKUP || req_type == lcn_pkg::REQ_INSERT) begin
            state_next = lcn_pkg::S_SCAN;
          end else begin
            state_next = lcn_pkg::S_DECIDE;
          end
        end
      end
      lcn_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = lcn_pkg::S_DECIDE;
        end
      end
      lcn_pkg::S_DECIDE: begin
        if (!out_valid || !out_stall) begin
          state_next = lcn_pkg::S_IDLE;
        end
      end
      default: state_next = lcn_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    decide_go = 1'b0;
    unique case (state)
      lcn_pkg::S_IDLE:   in_stall = 1'b0;
      lcn_pkg::S_SCAN:   ram_re = !scan_last;
      lcn_pkg::S_DECIDE: decide_go = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // decide datapath
  always_comb begin
    cnt_inc   = use_counter + 64'd1;
    deadline  = {16'd0, now_q} + {32'd0, retry_ms};
    ins_slot  = sres.hit ? sres.hit_slot :
                sres.free_any ? sres.free_slot :
                sres.neg_any ? sres.neg_slot : sres.lru_slot;
    wr_en     = 1'b0;
    wr_slot   = sres.hit_slot;
    wr_entry  = '{tag: key_q, handle: hin_q, stamp: cnt_inc};
    set_valid = 1'b0;
    clr_valid = 1'b0;
    clear_all = 1'b0;
    cnt_load  = 1'b0;
    cnt_val   = cnt_inc;
    st_d      = lcn_pkg::ST_MISS;
    hout_d    = 32'd0;
    ev_d      = 1'b0;
    evh_d     = 32'd0;
    case (req_q)
      lcn_pkg::REQ_LOOKUP: begin
        if (sres.hit) begin
          if (sres.hit_handle != 32'd0) begin
            wr_en    = 1'b1;
            wr_entry = '{tag: key_q, handle: sres.hit_handle, stamp: cnt_inc};
            cnt_load = 1'b1;
            st_d     = lcn_pkg::ST_HIT;
            hout_d   = sres.hit_handle;
          end else if ({16'd0, now_q} < sres.hit_stamp) begin
            st_d = lcn_pkg::ST_HOLD;
          end else begin
            // expired negative entry drops out
            clr_valid = 1'b1;
          end
        end
      end
      lcn_pkg::REQ_INSERT: begin
        wr_en     = 1'b1;
        wr_slot   = ins_slot;
        set_valid = 1'b1;
        if (hin_q != 32'd0) begin
          cnt_load = 1'b1;
        end else begin
          wr_entry = '{tag: key_q, handle: hin_q, stamp: deadline};
        end
        st_d   = lcn_pkg::ST_INSERTED;
        hout_d = hin_q;
        if (sres.hit) begin
          if (sres.hit_handle != 32'd0 && sres.hit_handle != hin_q) begin
            ev_d  = 1'b1;
            evh_d = sres.hit_handle;
          end
        end else if (!sres.free_any) begin
          ev_d  = 1'b1;
          evh_d = sres.neg_any ? 32'd0 : sres.lru_handle;
        end
      end
      lcn_pkg::REQ_CLEAR: begin
        clear_all = 1'b1;
        cnt_load  = 1'b1;
        cnt_val   = 64'd0;
        st_d      = lcn_pkg::ST_CLEARED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lcn_pkg::S_IDLE;
      retry_ms    <= lcn_pkg::RETRY_MS_RESET;
      use_counter <= 64'd0;
      entry_valid <= '0;
      cnt         <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= ram_re;
      if (cfg_we) begin
        retry_ms <= cfg_wdata;
      end
      if (in_acc) begin
        cnt <= '0;
      end else if (ram_re) begin
        cnt <= cnt + lcn_pkg::CNT_W'(1);
      end
      if (decide_go) begin
        if (cnt_load) begin
          use_counter <= cnt_val;
        end
        if (clear_all) begin
          entry_valid <= '0;
        end else if (set_valid) begin
          entry_valid[wr_slot] <= 1'b1;
        end else if (clr_valid) begin
          entry_valid[sres.hit_slot] <= 1'b0;
        end
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= ram_raddr;
    if (in_acc) begin
      req_q <= req_type;
      key_q <= key_tag;
      hin_q <= handle_in;
      now_q <= now_ms;
    end
    if (decide_go) begin
      status         <= st_d;
      handle_out     <= hout_d;
      evicted        <= ev_d;
      evicted_handle <= evh_d;
    end
  end

  // memory writes come only from the decide step
  a_we_in_decide: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == lcn_pkg::S_DECIDE)
    else $error("entry write outside decide step");

  // a full scan always ends in the decide step
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == lcn_pkg::S_SCAN && scan_last) |=> state == lcn_pkg::S_DECIDE)
    else $error("scan did not hand over to decide");

  // an inserted slot is valid afterwards
  a_ins_valid: assert property (@(posedge clk) disable iff (rst)
    (ram_we && req_q == lcn_pkg::REQ_INSERT) |=> entry_valid[$past(wr_slot)])
    else $error("inserted slot not marked valid");

  // a new result only follows a decide step
  a_out_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == lcn_pkg::S_DECIDE)
    else $error("result appeared without a decide step");

  // no read of the memory while a transaction can be taken
  a_no_read_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !ram_re && !ram_we)
    else $error("memory access while idle");

endmodule
